// ===== sv/lob_pkg.sv =====
// Package for the limit order book core: opcodes, status codes, request word type.
// No dependencies.
`default_nettype none
package lob_pkg;
  localparam int unsigned OrderSlotsDefault = 256;
  localparam int unsigned ReqQueueDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] order_ident;
    logic        is_buy;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIND,
    BK_APPLY,
    BK_SCAN,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

// ===== sv/lob_front.sv =====
// Front part of the order book: accepts request words into a small queue.
// Depends on lob_pkg.
`default_nettype none
module lob_front
  import lob_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] order_ident,
  input  wire logic        is_buy,
  input  wire logic [31:0] limit_price,
  input  wire logic [31:0] quantity,
  output logic             req_valid,
  input  wire logic        req_take,
  output req_t             req
);
  localparam int unsigned AW = $clog2(ReqQueueDepth);
  req_t          q [ReqQueueDepth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign stall     = (count == (AW+1)'(ReqQueueDepth));
  assign push      = valid && !stall;
  assign req_valid = (count != '0);
  assign pop       = req_valid && req_take;
  assign req       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= '{opcode, order_ident, is_buy, limit_price, quantity};
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== sv/lob_back.sv =====
// Back part of the order book: slot memory, id match, update and best bid/ask scan.
// Depends on lob_pkg.
`default_nettype none
module lob_back
  import lob_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = OrderSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_take,
  input  req_t             req,
  output logic             valid,
  input  wire logic        stall,
  output logic [1:0]       status,
  output logic             found_buy,
  output logic [31:0]      found_price,
  output logic [31:0]      found_remaining,
  output logic             bid_valid,
  output logic [31:0]      bid_id,
  output logic [31:0]      bid_price,
  output logic [31:0]      bid_remaining,
  output logic             ask_valid,
  output logic [31:0]      ask_id,
  output logic [31:0]      ask_price,
  output logic [31:0]      ask_remaining
);
  localparam int unsigned SW = $clog2(ORDER_SLOTS);

  // Slot record; used bits are flip-flops, the rest a memory.
  typedef struct packed {
    logic [31:0] ident;
    logic        buy;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [63:0] arrival;
  } slot_t;

  slot_t             mem [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] used;
  slot_t             rd;
  logic [SW-1:0]     rd_addr;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  slot_t             wr_data;

  bk_state_t state, state_next;
  req_t      cur;
  logic [SW:0] idx;        // scan index, one beyond for the read latency
  logic        rd_ok;      // rd holds slot idx-1
  logic [SW-1:0] rd_slot;
  logic        hit;
  logic [SW-1:0] hit_slot;
  logic        have_free;
  logic [SW-1:0] free_slot;
  logic [63:0] arrival_counter;
  slot_t       hit_rec;
  logic [1:0]  st;
  logic        f_valid;
  slot_t       f_rec;
  logic        b_valid, a_valid;
  slot_t       b_rec, a_rec;
  logic        rd_used;
  logic        b_take, a_take;
  logic        requeue;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  assign rd_addr = idx[SW-1:0];
  assign rd_used = used[rd_slot];
  assign requeue = (cur.limit_price != hit_rec.price) || (cur.quantity > hit_rec.remaining);

  always_comb begin
    b_take = rd_ok && rd_used && rd.buy &&
             (!b_valid || rd.price > b_rec.price ||
              (rd.price == b_rec.price && rd.arrival < b_rec.arrival));
    a_take = rd_ok && rd_used && !rd.buy &&
             (!a_valid || rd.price < a_rec.price ||
              (rd.price == a_rec.price && rd.arrival < a_rec.arrival));
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (req_valid) state_next = BK_FIND;
      BK_FIND:  if (idx == (SW+1)'(ORDER_SLOTS) && !rd_ok) state_next = BK_APPLY;
      BK_APPLY: state_next = BK_SCAN;
      BK_SCAN:  if (idx == (SW+1)'(ORDER_SLOTS) && !rd_ok) state_next = BK_OUT;
      BK_OUT:   if (!stall) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    req_take = (state == BK_IDLE) && req_valid;
    valid    = (state == BK_OUT);
    wr_en    = 1'b0;
    wr_addr  = hit_slot;
    wr_data  = hit_rec;
    if (state == BK_APPLY) begin
      if (cur.opcode == OP_ADD && !hit && have_free) begin
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = '{cur.order_ident, cur.is_buy, cur.limit_price, cur.quantity,
                    arrival_counter};
      end else if (cur.opcode == OP_MODIFY && hit) begin
        wr_en = 1'b1;
        wr_data.remaining = cur.quantity;
        if (requeue) begin
          wr_data.price   = cur.limit_price;
          wr_data.arrival = arrival_counter;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      used  <= '0;
      arrival_counter <= '0;
      rd_ok <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      rd_ok <= ((state == BK_FIND) || (state == BK_SCAN)) &&
               (idx != (SW+1)'(ORDER_SLOTS));
      case (state)
        BK_IDLE: begin
          idx <= '0;
          if (req_valid) cur <= req;
          hit <= 1'b0;
          have_free <= 1'b0;
        end
        BK_FIND, BK_SCAN: begin
          if (idx != (SW+1)'(ORDER_SLOTS)) begin
            idx     <= idx + (SW+1)'(1);
            rd_slot <= idx[SW-1:0];
          end
          if (state == BK_FIND && rd_ok) begin
            if (rd_used && rd.ident == cur.order_ident) begin
              hit <= 1'b1;
              hit_slot <= rd_slot;
              hit_rec <= rd;
            end
            if (!rd_used && !have_free) begin
              have_free <= 1'b1;
              free_slot <= rd_slot;
            end
          end
          if (state == BK_SCAN) begin
            if (b_take) begin
              b_valid <= 1'b1;
              b_rec <= rd;
            end
            if (a_take) begin
              a_valid <= 1'b1;
              a_rec <= rd;
            end
          end
        end
        BK_APPLY: begin
          idx <= '0;
          b_valid <= 1'b0;
          a_valid <= 1'b0;
          case (cur.opcode)
            OP_ADD: begin
              // A duplicate reports the order that already rests.
              st      <= hit ? ST_DUP : (have_free ? ST_OK : ST_FULL);
              f_valid <= hit || have_free;
              f_rec   <= hit ? hit_rec : wr_data;
              if (!hit && have_free) begin
                used[free_slot] <= 1'b1;
                arrival_counter <= arrival_counter + 64'd1;
              end
            end
            OP_CANCEL: begin
              st      <= hit ? ST_OK : ST_NOT_FOUND;
              f_valid <= 1'b0;
              f_rec   <= hit_rec;
              if (hit) used[hit_slot] <= 1'b0;
            end
            OP_MODIFY: begin
              st <= hit ? ST_OK : ST_NOT_FOUND;
              f_valid <= hit;
              f_rec   <= wr_data;
              if (hit && requeue) arrival_counter <= arrival_counter + 64'd1;
            end
            default: begin
              st <= hit ? ST_OK : ST_NOT_FOUND;
              f_valid <= hit;
              f_rec   <= hit_rec;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign status          = st;
  assign found_buy       = f_valid && f_rec.buy;
  assign found_price     = f_valid ? f_rec.price : 32'd0;
  assign found_remaining = f_valid ? f_rec.remaining : 32'd0;
  assign bid_valid       = b_valid;
  assign bid_id          = b_valid ? b_rec.ident : 32'd0;
  assign bid_price       = b_valid ? b_rec.price : 32'd0;
  assign bid_remaining   = b_valid ? b_rec.remaining : 32'd0;
  assign ask_valid       = a_valid;
  assign ask_id          = a_valid ? a_rec.ident : 32'd0;
  assign ask_price       = a_valid ? a_rec.price : 32'd0;
  assign ask_remaining   = a_valid ? a_rec.remaining : 32'd0;
endmodule
`default_nettype wire

// ===== sv/limit_order_book_core.sv =====
// Limit order book core: top level joining the request queue and the execution back end.
// Depends on lob_pkg, lob_front and lob_back.
//
// Use: a request word (opcode, order_ident, is_buy, limit_price, quantity) is taken
// on the input channel at an edge with in_valid high and in_stall low. Each request
// gives exactly one result word on the output channel, taken when out_valid is high
// and out_stall is low. Results stay in order.
// The slot memory has one read port: one pass over all slots finds the id and the
// first free slot, the update is written, and a second pass picks the best bid and
// ask. The back end takes a new request only once the last result has been taken.
// A two-word queue lets new requests arrive while the back end works.
// Reset empties the book and the queue and zeroes the arrival counter; no
// clearing pass is needed. While the receiver stalls, the result holds and the
// back end waits; the queue then fills and the input stalls.
`default_nettype none
module limit_order_book_core
  import lob_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = OrderSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] order_ident,
  input  wire logic        is_buy,
  input  wire logic [31:0] limit_price,
  input  wire logic [31:0] quantity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             found_buy,
  output logic [31:0]      found_price,
  output logic [31:0]      found_remaining,
  output logic             bid_valid,
  output logic [31:0]      bid_id,
  output logic [31:0]      bid_price,
  output logic [31:0]      bid_remaining,
  output logic             ask_valid,
  output logic [31:0]      ask_id,
  output logic [31:0]      ask_price,
  output logic [31:0]      ask_remaining
);
  logic req_valid;
  logic req_take;
  req_t req;

  lob_front u_front (
    .clk, .rst,
    .valid(in_valid), .stall(in_stall),
    .opcode, .order_ident, .is_buy, .limit_price, .quantity,
    .req_valid, .req_take, .req
  );

  lob_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
    .clk, .rst,
    .req_valid, .req_take, .req,
    .valid(out_valid), .stall(out_stall),
    .status, .found_buy, .found_price, .found_remaining,
    .bid_valid, .bid_id, .bid_price, .bid_remaining,
    .ask_valid, .ask_id, .ask_price, .ask_remaining
  );
endmodule
`default_nettype wire
